[src/sts_pkg.sv]
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // The search window bounds need one extra bit so that hi can reach -1.
    localparam int WIN_W       = CNT_W + 1;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 12;
    localparam int KIND_W      = 2;
    localparam int SUM_W       = CNT_W + POS_W;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [POS_W-1:0] POS_NOT_FOUND = {POS_W{1'b1}};

    typedef struct packed {
        logic clear;
        logic append;
        logic load;
        logic start;
        logic step;
        logic emit;
    } sts_cmd_t;

    typedef struct packed {
        logic finish;
    } sts_status_t;

endpackage

[src/sts_ram.sv]
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sts_datapath.sv]
module sts_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sts_pkg::sts_cmd_t                    cmd,
    input  logic signed [sts_pkg::VALUE_W-1:0]   value,
    output sts_pkg::sts_status_t                 status,
    output logic signed [sts_pkg::POS_W-1:0]     position,
    output logic [sts_pkg::CNT_W-1:0]            entry_count
);

    import sts_pkg::*;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [WIN_W-1:0]   lo_reg;
    logic signed [WIN_W-1:0]   lo_next;
    logic signed [WIN_W-1:0]   hi_reg;
    logic signed [WIN_W-1:0]   hi_next;
    logic signed [WIN_W-1:0]   mid_reg;
    logic signed [WIN_W-1:0]   mid_next;
    logic [WIN_W:0]            bound_sum;
    logic [POS_W-1:0]          res_reg;
    logic [POS_W-1:0]          res_next;
    logic [POS_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      wr_en;
    logic                      rd_en;
    logic                      equal;
    logic                      go_up;
    logic                      window_empty;

    assign wr_en = cmd.append && (count_reg < CNT_W'(TABLE_DEPTH));
    assign rd_en = cmd.start || cmd.step;

    sts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (mid_next[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign equal = (rd_data == key_reg);
    assign go_up = (key_reg > rd_data);

    // The next window is formed and its midpoint read in the same cycle that
    // the previous probe is compared, so one entry is probed per cycle.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.start)
        begin
            lo_next = '0;
            hi_next = WIN_W'(count_reg) - WIN_W'(1);
        end
        else if (cmd.step)
        begin
            if (go_up)
            begin
                lo_next = mid_reg + WIN_W'(1);
            end
            else
            begin
                hi_next = mid_reg - WIN_W'(1);
            end
        end
        bound_sum    = {lo_next[WIN_W-1], lo_next} + {hi_next[WIN_W-1], hi_next};
        mid_next     = bound_sum[WIN_W:1];
        window_empty = (lo_next > hi_next);
    end

    always_comb
    begin
        status.finish = (cmd.start && window_empty)
                     || (cmd.step && (equal || window_empty));
        if (cmd.step && equal)
        begin
            res_next = POS_W'(SUM_W'(mid_reg[CNT_W-1:0]) + SUM_W'(1));
        end
        else
        begin
            res_next = POS_NOT_FOUND;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= value;
        end
        if (rd_en)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (status.finish)
        begin
            res_reg <= res_next;
        end
        if (cmd.emit)
        begin
            pos_reg <= res_reg;
        end
    end

    assign position    = pos_reg;
    assign entry_count = count_reg;

endmodule

[src/sts_controller.sv]
module sts_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sts_pkg::KIND_W-1:0]   kind,
    input  logic                         out_stall,
    input  sts_pkg::sts_status_t         status,
    output logic                         in_stall,
    output logic                         out_valid,
    output sts_pkg::sts_cmd_t            cmd
);

    import sts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.clear  = accept && (kind == KIND_CLEAR);
        cmd.append = accept && (kind == KIND_APPEND);
        cmd.load   = accept && (kind == KIND_QUERY);
        cmd.start  = (state_reg == ST_START);
        cmd.step   = (state_reg == ST_PROBE);
        cmd.emit   = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_START;
                end
            end
            ST_START, ST_PROBE:
            begin
                state_next = status.finish ? ST_DONE : ST_PROBE;
            end
            ST_DONE:
            begin
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/sorted_table_binary_search_unit.sv]
// Sorted-table binary search unit.
// Input channel (in_valid, in_stall, kind, value): kind 0 clears the table,
// kind 1 appends value as the next entry (dropped once the table is full),
// kind 2 searches for value, and kind 3 is ignored. A transfer takes place
// when in_valid is high and in_stall is low.
// Output channel (out_valid, out_stall, position): one transfer per search,
// carrying the 1-based position of the first probed match or -1.
// Clear and append items are taken back to back. A search holds in_stall
// high from the query transfer until its answer goes to the output
// register, through the table probes (at most log2 of the table depth plus
// one, 11 for 1024 entries): a start state reads the first midpoint, a probe
// state takes one probe per cycle through the registered RAM read port, and
// a done state hands the answer to the output register.
// When the receiver stalls, the result stays in the output register and the
// next items are still taken until another search finishes, which then
// waits for the output register to empty.
// Reset empties the table and drops any search in flight; table contents
// are not cleared and need no clearing pass.
module sorted_table_binary_search_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sts_pkg::KIND_W-1:0]           kind,
    input  logic signed [sts_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [sts_pkg::POS_W-1:0]     position
);

    import sts_pkg::*;

    sts_cmd_t         cmd;
    sts_status_t      status;
    logic [CNT_W-1:0] entry_count;

    sts_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    sts_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    // A query transfer always starts a search that blocks the input.
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_QUERY) |=> in_stall)
        else $error("query transfer did not start a search");

    // A result only appears at the end of a search.
    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search");

    // The entry count never passes the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Every search step issues a RAM read, so a search cannot end while idle.
    a_finish_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        status.finish |-> in_stall && (cmd.start || cmd.step))
        else $error("search finished outside a search");

endmodule
